>>> rtl/core/css_pkg.sv
package css_pkg;

   // character codes the parser looks for
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_LOW_B  = 8'h62;
   localparam logic [7:0] CH_LOW_G  = 8'h67;
   localparam logic [7:0] CH_LOW_R  = 8'h72;

   localparam logic [7:0] FULL_ALPHA = 8'hFF;

   typedef struct packed {
      logic       is_space;
      logic       is_digit;
      logic       is_hex;
      logic [3:0] hex_val;
   } char_class_type;

   typedef struct packed {
      logic            ok;
      logic [3:0][7:0] comp;
   } hex_result_type;

   typedef struct packed {
      logic       color_valid;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } result_type;

   // expand collected hex digits into r, g, b, a (comp[0] is red)
   function automatic hex_result_type hex_decode(input logic [31:0] nib,
                                                 input logic [3:0]  cnt);
      hex_result_type r;
      r.ok   = 1'b1;
      r.comp = '0;
      case (cnt)
         4'd3: begin
            r.comp[0] = {nib[11:8], nib[11:8]};
            r.comp[1] = {nib[7:4], nib[7:4]};
            r.comp[2] = {nib[3:0], nib[3:0]};
            r.comp[3] = FULL_ALPHA;
         end
         4'd4: begin
            r.comp[0] = {nib[15:12], nib[15:12]};
            r.comp[1] = {nib[11:8], nib[11:8]};
            r.comp[2] = {nib[7:4], nib[7:4]};
            r.comp[3] = {nib[3:0], nib[3:0]};
         end
         4'd6: begin
            r.comp[0] = nib[23:16];
            r.comp[1] = nib[15:8];
            r.comp[2] = nib[7:0];
            r.comp[3] = FULL_ALPHA;
         end
         4'd8: begin
            r.comp[0] = nib[31:24];
            r.comp[1] = nib[23:16];
            r.comp[2] = nib[15:8];
            r.comp[3] = nib[7:0];
         end
         default: r.ok = 1'b0;
      endcase
      return r;
   endfunction

   // round(255*v/100) for v in 0..100; divide by 100 as multiply by 2^19/100
   function automatic logic [7:0] pct_scale(input logic [6:0] v);
      logic [14:0] x;
      logic [27:0] prod;
      x    = ({v, 8'd0} - {8'd0, v}) + 15'd50;
      prod = {13'd0, x} * 28'd5243;
      return prod[26:19];
   endfunction

endpackage

>>> rtl/core/css_char_class.sv
module css_char_class
   import css_pkg::*;
(
   input  logic [7:0]     char_code,
   output char_class_type cls
);

   logic is_num;
   logic is_upper_hex;
   logic is_lower_hex;

   assign is_num       = (char_code >= 8'h30) && (char_code <= 8'h39);
   assign is_upper_hex = (char_code >= 8'h41) && (char_code <= 8'h46);
   assign is_lower_hex = (char_code >= 8'h61) && (char_code <= 8'h66);

   always_comb begin
      cls.is_space = (char_code == 8'h20) || ((char_code >= 8'h09) && (char_code <= 8'h0D));
      cls.is_digit = is_num;
      cls.is_hex   = is_num || is_upper_hex || is_lower_hex;
      if (is_num) begin
         cls.hex_val = char_code[3:0];
      end else if (is_upper_hex || is_lower_hex) begin
         cls.hex_val = char_code[3:0] + 4'd9;
      end else begin
         cls.hex_val = 4'd0;
      end
   end

endmodule

>>> rtl/core/css_parse_core.sv
module css_parse_core
   import css_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] char_code,
   input  logic       last_char,
   output logic       res_load,
   output result_type res
);

   localparam logic [4:0] PH_START  = 5'd0;
   localparam logic [4:0] PH_HEX    = 5'd1;
   localparam logic [4:0] PH_R      = 5'd2;
   localparam logic [4:0] PH_RG     = 5'd3;
   localparam logic [4:0] PH_PAREN  = 5'd4;
   localparam logic [4:0] PH_LEAD   = 5'd5;
   localparam logic [4:0] PH_SIGN   = 5'd6;
   localparam logic [4:0] PH_NUM    = 5'd7;
   localparam logic [4:0] PH_AFTNUM = 5'd8;
   localparam logic [4:0] PH_AFTPCT = 5'd9;

   localparam logic [1:0] V_PENDING = 2'd0;
   localparam logic [1:0] V_VALID   = 2'd1;
   localparam logic [1:0] V_INVALID = 2'd2;

   char_class_type  cls;
   hex_result_type  fin;

   logic [4:0]      phase_ff, phase_in;
   logic [31:0]     nib_ff, nib_in, nib_nx;
   logic [3:0]      cnt_ff, cnt_in, cnt_nx;
   logic [8:0]      acc_ff, acc_in;
   logic            neg_ff, neg_in;
   logic [1:0]      idx_ff, idx_in;
   logic [3:0][7:0] comp_ff, comp_in;
   logic [1:0]      verdict_ff, verdict_in;

   logic            feeding;
   logic            hex_take;
   logic [12:0]     acc_mul;
   logic [8:0]      acc_dig;
   logic            sign_ok;
   logic            pct_ok;
   logic            int_ok;

   css_char_class u_class (
      .char_code (char_code),
      .cls       (cls)
   );

   assign feeding  = step && (verdict_ff == V_PENDING);
   assign hex_take = feeding && (phase_ff == PH_HEX) && cls.is_hex;
   assign nib_nx   = (hex_take && (cnt_ff < 4'd8)) ? {nib_ff[27:0], cls.hex_val} : nib_ff;
   assign cnt_nx   = (hex_take && (cnt_ff < 4'd9)) ? cnt_ff + 4'd1 : cnt_ff;
   assign fin      = hex_decode(nib_nx, cnt_nx);

   // saturate at 511, which is out of range for every component
   assign acc_mul = {1'b0, acc_ff, 3'd0} + {3'd0, acc_ff, 1'b0} + {9'd0, cls.hex_val};
   assign acc_dig = (acc_mul > 13'd511) ? 9'd511 : acc_mul[8:0];

   assign sign_ok = !(neg_ff && (acc_ff != 9'd0));
   assign pct_ok  = sign_ok && (acc_ff <= 9'd100);
   assign int_ok  = sign_ok && (acc_ff <= 9'd255);

   always_comb begin
      logic end_num;
      logic sep_req;
      end_num    = 1'b0;
      sep_req    = 1'b0;
      phase_in   = phase_ff;
      nib_in     = nib_nx;
      cnt_in     = cnt_nx;
      acc_in     = acc_ff;
      neg_in     = neg_ff;
      idx_in     = idx_ff;
      comp_in    = comp_ff;
      verdict_in = verdict_ff;
      res_load   = 1'b0;
      res        = '0;

      if (feeding) begin
         unique case (phase_ff)
            PH_START: begin
               if (char_code == CH_HASH) begin
                  phase_in = PH_HEX;
               end else if (char_code == CH_LOW_R) begin
                  phase_in = PH_R;
               end else begin
                  verdict_in = V_INVALID;
               end
            end
            PH_HEX: begin
               if (!cls.is_hex) begin
                  if (fin.ok) begin
                     comp_in    = fin.comp;
                     verdict_in = V_VALID;
                  end else begin
                     verdict_in = V_INVALID;
                  end
               end
            end
            PH_R: begin
               if (char_code == CH_LOW_G) phase_in = PH_RG;
               else verdict_in = V_INVALID;
            end
            PH_RG: begin
               if (char_code == CH_LOW_B) phase_in = PH_PAREN;
               else verdict_in = V_INVALID;
            end
            PH_PAREN: begin
               if (char_code == CH_LPAREN) phase_in = PH_LEAD;
               else if (!cls.is_space) verdict_in = V_INVALID;
            end
            PH_LEAD: begin
               if (cls.is_space) begin
                  phase_in = PH_LEAD;
               end else if (char_code == CH_MINUS) begin
                  neg_in   = 1'b1;
                  phase_in = PH_SIGN;
               end else if (cls.is_digit) begin
                  acc_in   = acc_dig;
                  phase_in = PH_NUM;
               end else begin
                  verdict_in = V_INVALID;
               end
            end
            PH_SIGN: begin
               if (cls.is_digit) begin
                  acc_in   = acc_dig;
                  phase_in = PH_NUM;
               end else begin
                  verdict_in = V_INVALID;
               end
            end
            PH_NUM: begin
               if (cls.is_digit) acc_in = acc_dig;
               else if (cls.is_space) phase_in = PH_AFTNUM;
               else end_num = 1'b1;
            end
            PH_AFTNUM: begin
               if (!cls.is_space) end_num = 1'b1;
            end
            PH_AFTPCT: begin
               if (cls.is_space) phase_in = PH_AFTPCT;
               else if ((char_code == CH_COMMA) || (char_code == CH_RPAREN)) sep_req = 1'b1;
               else verdict_in = V_INVALID;
            end
            default: verdict_in = V_INVALID;
         endcase

         // close the current component
         if (end_num) begin
            if (char_code == CH_PCT) begin
               if (pct_ok) begin
                  comp_in[idx_ff] = pct_scale(acc_ff[6:0]);
                  phase_in        = PH_AFTPCT;
               end else begin
                  verdict_in = V_INVALID;
               end
            end else if ((char_code == CH_COMMA) || (char_code == CH_RPAREN)) begin
               if (int_ok) begin
                  comp_in[idx_ff] = acc_ff[7:0];
                  sep_req         = 1'b1;
               end else begin
                  verdict_in = V_INVALID;
               end
            end else begin
               verdict_in = V_INVALID;
            end
         end

         if (sep_req) begin
            if ((char_code == CH_COMMA) && (idx_ff != 2'd3)) begin
               idx_in   = idx_ff + 2'd1;
               acc_in   = 9'd0;
               neg_in   = 1'b0;
               phase_in = PH_LEAD;
            end else if ((char_code == CH_RPAREN) && (idx_ff >= 2'd2)) begin
               if (idx_ff == 2'd2) comp_in[3] = FULL_ALPHA;
               verdict_in = V_VALID;
            end else begin
               verdict_in = V_INVALID;
            end
         end
      end

      // final byte: settle the verdict, emit, and start over
      if (step && last_char) begin
         res_load = 1'b1;
         if ((verdict_in == V_PENDING) && (phase_in == PH_HEX) && fin.ok) begin
            res.color_valid = 1'b1;
            res.red         = fin.comp[0];
            res.green       = fin.comp[1];
            res.blue        = fin.comp[2];
            res.alpha       = fin.comp[3];
         end else if (verdict_in == V_VALID) begin
            res.color_valid = 1'b1;
            res.red         = comp_in[0];
            res.green       = comp_in[1];
            res.blue        = comp_in[2];
            res.alpha       = comp_in[3];
         end
         phase_in   = PH_START;
         nib_in     = '0;
         cnt_in     = '0;
         acc_in     = '0;
         neg_in     = 1'b0;
         idx_in     = '0;
         comp_in    = '0;
         verdict_in = V_PENDING;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_START;
         nib_ff     <= '0;
         cnt_ff     <= '0;
         acc_ff     <= '0;
         neg_ff     <= 1'b0;
         idx_ff     <= '0;
         comp_ff    <= '0;
         verdict_ff <= V_PENDING;
      end else begin
         phase_ff   <= phase_in;
         nib_ff     <= nib_in;
         cnt_ff     <= cnt_in;
         acc_ff     <= acc_in;
         neg_ff     <= neg_in;
         idx_ff     <= idx_in;
         comp_ff    <= comp_in;
         verdict_ff <= verdict_in;
      end
   end

endmodule

>>> rtl/core/css_color_string_parser.sv
// Color text parser: '#' hex colors (3, 4, 6 or 8 digits) and rgb(...) with three
// or four integer or percent components.
// Request channel (req_): one byte of text per request, req_tlast on the final
// byte of a string. Response channel (rsp_): one response per string, issued for
// the request that carried req_tlast. rsp_tuser[0] flags a valid color;
// rsp_tdata carries red, green, blue, alpha (all zero when invalid).
// Throughput: one request per cycle, sustained, including across string ends,
// unless a held response stalls a final byte (see Stalls). Response path: the
// final byte waits in the request register while the parser works on it, and the
// result is loaded into the response register at the next edge.
// Stalls: a held response blocks only a request that ends a string; other bytes
// keep flowing through the parser while the response waits.
// Reset: synchronous; clears both handshake registers and puts the parser back
// at the start of a string.
module css_color_string_parser
   import css_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // last_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
   output logic        rsp_tuser    // [0] color_valid
);

   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_char_ff;
   logic       in_last_ff;
   logic       out_vld_ff, out_vld_in;
   result_type out_ff;
   logic       out_free;
   logic       step;
   logic       res_load;
   result_type res;

   assign out_free   = !out_vld_ff || rsp_tready;
   assign step       = in_vld_ff && (!in_last_ff || out_free);
   assign req_tready = !in_vld_ff || step;
   assign in_vld_in  = req_tready ? req_tvalid : in_vld_ff;
   assign out_vld_in = res_load ? 1'b1 : (rsp_tready ? 1'b0 : out_vld_ff);

   css_parse_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .char_code (in_char_ff),
      .last_char (in_last_ff),
      .res_load  (res_load),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (res_load) begin
         out_ff <= res;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {out_ff.alpha, out_ff.blue, out_ff.green, out_ff.red};
   assign rsp_tuser  = out_ff.color_valid;

endmodule

>>> rtl/core/css_checker.sv
module css_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // an invalid color reports all components as zero
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 32'd0)
      else $error("invalid color with nonzero components");

   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response pending after reset");

   a_reset_req: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("request side not ready after reset");

endmodule

bind css_color_string_parser css_checker u_css_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
